// ===== hdl/square_path_drive_turn_controller_macros.svh =====
// Assertion macros used by the square path controller top module.
`ifndef SQUARE_PATH_DRIVE_TURN_CONTROLLER_MACROS_SVH
`define SQUARE_PATH_DRIVE_TURN_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define SQDRV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqdrv assertion failed");
// Next-cycle implication, checked outside reset.
`define SQDRV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqdrv assertion failed");
`else
`define SQDRV_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SQDRV_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/sqdrv_pkg.sv =====
`default_nettype none

package sqdrv_pkg;

   // fixed point format of lengths, speeds, angles and gains
   localparam int FRAC_BITS  = 12;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   // field widths
   localparam int POS_W   = 16;
   localparam int HEAD_W  = 15;
   localparam int LEN_W   = 15;
   localparam int MAR_W   = 12;
   localparam int GAIN_W  = 14;
   localparam int SPEED_W = 14;
   localparam int ANG_W   = 18;
   localparam int ANGLE_W = 17;   // heading differences and angle constants
   localparam int CROSS_W = 18;   // cross-track error
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // angle constants, real value times 2^FRAC_BITS rounded to nearest
   localparam logic signed [ANGLE_W-1:0] K_TURN_END    = 17'sd5820;   // pi/2 - 0.15
   localparam logic signed [ANGLE_W-1:0] K_HALF_PI     = 17'sd6434;
   localparam logic signed [ANGLE_W-1:0] K_PI          = 17'sd12868;
   localparam logic signed [ANGLE_W-1:0] K_ONE_HALF_PI = 17'sd19302;  // 3*pi/2
   localparam logic signed [ANGLE_W-1:0] K_ONE_SIX_PI  = 17'sd20589;
   localparam logic signed [ANGLE_W-1:0] K_TWO_PI      = 17'sd25736;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_MARGIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_SPEED   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_RATE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_GAIN    = 3'd5;

   // modes
   localparam logic MODE_DRIVE = 1'b0;
   localparam logic MODE_TURN  = 1'b1;

   // sides of the square
   localparam logic [1:0] SIDE_0 = 2'd0;
   localparam logic [1:0] SIDE_1 = 2'd1;
   localparam logic [1:0] SIDE_2 = 2'd2;
   localparam logic [1:0] SIDE_3 = 2'd3;

   typedef struct packed {
      logic [LEN_W-1:0]   side_length;
      logic [MAR_W-1:0]   arrive_margin;
      logic [SPEED_W-1:0] drive_speed;
      logic [SPEED_W-1:0] turn_rate;
      logic [GAIN_W-1:0]  heading_gain;
      logic [GAIN_W-1:0]  cross_gain;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/sqdrv_drive_law.sv =====
`default_nettype none

// Proportional steering law on heading error and cross-track error.
module sqdrv_drive_law (
   input  wire logic [1:0]                             side,
   input  wire logic signed [sqdrv_pkg::POS_W-1:0]     pos_x,
   input  wire logic signed [sqdrv_pkg::POS_W-1:0]     pos_y,
   input  wire logic signed [sqdrv_pkg::HEAD_W-1:0]    heading,
   input  wire sqdrv_pkg::cfg_type                     cfg,
   output logic signed [sqdrv_pkg::ANG_W-1:0]          angular_speed
);

   localparam int PH_W  = sqdrv_pkg::GAIN_W + 1 + sqdrv_pkg::ANGLE_W;
   localparam int PE_W  = sqdrv_pkg::GAIN_W + 1 + sqdrv_pkg::CROSS_W;
   localparam int SUM_W = PE_W + 2;
   localparam int RND_W = SUM_W - sqdrv_pkg::FRAC_BITS;

   localparam logic signed [RND_W-1:0] SAT_MAX =
      RND_W'((1 <<< (sqdrv_pkg::ANG_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] SAT_MIN =
      RND_W'(-(1 <<< (sqdrv_pkg::ANG_W - 1)));

   logic signed [sqdrv_pkg::ANGLE_W-1:0] tgt;
   logic signed [sqdrv_pkg::ANGLE_W-1:0] t_raw;
   logic signed [sqdrv_pkg::ANGLE_W-1:0] t_wrap;
   logic signed [sqdrv_pkg::CROSS_W-1:0] x_ext;
   logic signed [sqdrv_pkg::CROSS_W-1:0] y_ext;
   logic signed [sqdrv_pkg::CROSS_W-1:0] len_ext;
   logic signed [sqdrv_pkg::CROSS_W-1:0] cross_err;
   logic signed [PH_W-1:0]               prod_h;
   logic signed [PE_W-1:0]               prod_e;
   logic signed [SUM_W-1:0]              sum;
   logic signed [RND_W-1:0]              rnd;

   assign x_ext   = sqdrv_pkg::CROSS_W'(pos_x);
   assign y_ext   = sqdrv_pkg::CROSS_W'(pos_y);
   assign len_ext = $signed({{(sqdrv_pkg::CROSS_W - sqdrv_pkg::LEN_W){1'b0}},
                             cfg.side_length});

   // pick target heading and cross-track error of the current side
   always_comb begin
      unique case (side)
         sqdrv_pkg::SIDE_0: begin
            tgt       = '0;
            cross_err = y_ext;
         end
         sqdrv_pkg::SIDE_1: begin
            tgt       = sqdrv_pkg::K_HALF_PI;
            cross_err = x_ext - len_ext;
         end
         sqdrv_pkg::SIDE_2: begin
            tgt       = sqdrv_pkg::K_PI;
            cross_err = y_ext - len_ext;
         end
         default: begin
            tgt       = sqdrv_pkg::K_ONE_HALF_PI;
            cross_err = x_ext;
         end
      endcase
   end

   // wrap heading error by a full turn when it runs past three quarters
   assign t_raw = tgt - sqdrv_pkg::ANGLE_W'(heading);

   always_comb begin
      priority if (t_raw > sqdrv_pkg::K_ONE_HALF_PI) begin
         t_wrap = t_raw - sqdrv_pkg::K_TWO_PI;
      end else if (t_raw < -sqdrv_pkg::K_ONE_HALF_PI) begin
         t_wrap = t_raw + sqdrv_pkg::K_TWO_PI;
      end else begin
         t_wrap = t_raw;
      end
   end

   // weigh both errors, round half up, saturate
   assign prod_h = PH_W'($signed({1'b0, cfg.heading_gain})) * PH_W'(t_wrap);
   assign prod_e = PE_W'($signed({1'b0, cfg.cross_gain})) * PE_W'(cross_err);
   assign sum    = SUM_W'(prod_h) + SUM_W'(prod_e) + SUM_W'(sqdrv_pkg::ROUND_HALF);
   assign rnd    = RND_W'(sum >>> sqdrv_pkg::FRAC_BITS);

   always_comb begin
      priority if (rnd > SAT_MAX) begin
         angular_speed = sqdrv_pkg::ANG_W'(SAT_MAX);
      end else if (rnd < SAT_MIN) begin
         angular_speed = sqdrv_pkg::ANG_W'(SAT_MIN);
      end else begin
         angular_speed = sqdrv_pkg::ANG_W'(rnd);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/square_path_drive_turn_controller.sv =====
`default_nettype none

// Channel   Direction  Width  Handshake            Contents
// req       in         48     req_tvalid/tready    one odometry sample
// rsp       out        40     rsp_tvalid/tready    speed and turn rate command
// csr       in         15     csr_we               register write, no read-back
//
// An item passes from acceptance through the input register, then through
// the steering law into the result register. One item per cycle is
// sustained while results are taken; the mode and side state updates as the
// item leaves the input register, so the next item sees it at once.
// Reset (synchronous, active high) clears mode, side and valid flags and loads cfg defaults.
// A stalled result holds both stages; the input register still fills if empty.

`include "square_path_drive_turn_controller_macros.svh"

module square_path_drive_turn_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // pos_x [15:0], pos_y [31:16], heading [46:32], zero [47]
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // linear_speed [13:0], angular_speed [31:14], turn_started [32],
   // mode_now [33], side_now [35:34], zero [39:36]
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_we,
   input  wire logic [sqdrv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sqdrv_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sqdrv_pkg::cfg_type cfg_ff;

   logic                                    in_valid_ff;
   logic                                    in_valid_in;
   logic signed [sqdrv_pkg::POS_W-1:0]      in_x_ff;
   logic signed [sqdrv_pkg::POS_W-1:0]      in_y_ff;
   logic signed [sqdrv_pkg::HEAD_W-1:0]     in_h_ff;

   logic                                    mode_ff;
   logic                                    mode_in;
   logic [1:0]                              side_ff;
   logic [1:0]                              side_in;
   logic signed [sqdrv_pkg::POS_W-1:0]      turn_heading_ff;

   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic [sqdrv_pkg::SPEED_W-1:0]           lin_ff;
   logic signed [sqdrv_pkg::ANG_W-1:0]      ang_ff;
   logic                                    started_ff;
   logic                                    mode_out_ff;
   logic [1:0]                              side_out_ff;

   logic                                    req_fire;
   logic                                    advance;
   logic                                    work;
   logic                                    arrive;
   logic                                    turn_done;
   logic                                    started;
   logic signed [sqdrv_pkg::ANGLE_W-1:0]    x_ext;
   logic signed [sqdrv_pkg::ANGLE_W-1:0]    y_ext;
   logic signed [sqdrv_pkg::ANGLE_W-1:0]    lim_hi;
   logic signed [sqdrv_pkg::ANGLE_W-1:0]    lim_lo;
   logic signed [sqdrv_pkg::ANGLE_W-1:0]    hdiff;
   logic signed [sqdrv_pkg::ANGLE_W-1:0]    hdiff_abs;
   logic signed [sqdrv_pkg::ANG_W-1:0]      law_ang;
   logic [sqdrv_pkg::SPEED_W-1:0]           lin_in;
   logic signed [sqdrv_pkg::ANG_W-1:0]      ang_in;

   // handshake: result stage moves when empty or taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign work       = in_valid_ff && advance;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = work || (rsp_valid_ff && !rsp_tready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.side_length   <= sqdrv_pkg::LEN_W'(4096);
         cfg_ff.arrive_margin <= sqdrv_pkg::MAR_W'(82);
         cfg_ff.drive_speed   <= sqdrv_pkg::SPEED_W'(2048);
         cfg_ff.turn_rate     <= sqdrv_pkg::SPEED_W'(6434);
         cfg_ff.heading_gain  <= sqdrv_pkg::GAIN_W'(5793);
         cfg_ff.cross_gain    <= sqdrv_pkg::GAIN_W'(4096);
      end else if (csr_we) begin
         unique case (csr_index)
            sqdrv_pkg::CSR_SIDE_LENGTH:
               cfg_ff.side_length <= csr_wdata[sqdrv_pkg::LEN_W-1:0];
            sqdrv_pkg::CSR_ARRIVE_MARGIN:
               cfg_ff.arrive_margin <= csr_wdata[sqdrv_pkg::MAR_W-1:0];
            sqdrv_pkg::CSR_DRIVE_SPEED:
               cfg_ff.drive_speed <= csr_wdata[sqdrv_pkg::SPEED_W-1:0];
            sqdrv_pkg::CSR_TURN_RATE:
               cfg_ff.turn_rate <= csr_wdata[sqdrv_pkg::SPEED_W-1:0];
            sqdrv_pkg::CSR_HEADING_GAIN:
               cfg_ff.heading_gain <= csr_wdata[sqdrv_pkg::GAIN_W-1:0];
            sqdrv_pkg::CSR_CROSS_GAIN:
               cfg_ff.cross_gain <= csr_wdata[sqdrv_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // arrival at the end line of the current side
   assign x_ext  = sqdrv_pkg::ANGLE_W'(in_x_ff);
   assign y_ext  = sqdrv_pkg::ANGLE_W'(in_y_ff);
   assign lim_lo = $signed({{(sqdrv_pkg::ANGLE_W - sqdrv_pkg::MAR_W){1'b0}},
                            cfg_ff.arrive_margin});
   assign lim_hi = $signed({{(sqdrv_pkg::ANGLE_W - sqdrv_pkg::LEN_W){1'b0}},
                            cfg_ff.side_length}) - lim_lo;

   always_comb begin
      unique case (side_ff)
         sqdrv_pkg::SIDE_0: arrive = x_ext > lim_hi;
         sqdrv_pkg::SIDE_1: arrive = y_ext > lim_hi;
         sqdrv_pkg::SIDE_2: arrive = x_ext < lim_lo;
         default:           arrive = y_ext < lim_lo;
      endcase
   end

   // end of turn: about a quarter turn since the latch
   assign hdiff     = sqdrv_pkg::ANGLE_W'(in_h_ff) - sqdrv_pkg::ANGLE_W'(turn_heading_ff);
   assign hdiff_abs = hdiff[sqdrv_pkg::ANGLE_W-1] ? -hdiff : hdiff;
   assign turn_done = (hdiff > sqdrv_pkg::K_TURN_END || hdiff < -sqdrv_pkg::K_TURN_END)
                      && hdiff_abs < sqdrv_pkg::K_ONE_SIX_PI;

   // next mode and side
   always_comb begin
      mode_in = mode_ff;
      side_in = side_ff;
      started = 1'b0;
      unique case (mode_ff)
         sqdrv_pkg::MODE_DRIVE: begin
            if (arrive) begin
               mode_in = sqdrv_pkg::MODE_TURN;
               side_in = side_ff + 2'd1;
               started = 1'b1;
            end
         end
         default: begin
            if (turn_done) begin
               mode_in = sqdrv_pkg::MODE_DRIVE;
            end
         end
      endcase
   end

   sqdrv_drive_law u_law (
      .side          (side_in),
      .pos_x         (in_x_ff),
      .pos_y         (in_y_ff),
      .heading       (in_h_ff),
      .cfg           (cfg_ff),
      .angular_speed (law_ang)
   );

   // command from the mode after the update
   always_comb begin
      unique case (mode_in)
         sqdrv_pkg::MODE_TURN: begin
            lin_in = '0;
            ang_in = $signed({{(sqdrv_pkg::ANG_W - sqdrv_pkg::SPEED_W){1'b0}},
                              cfg_ff.turn_rate});
         end
         default: begin
            lin_in = cfg_ff.drive_speed;
            ang_in = law_ang;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= sqdrv_pkg::MODE_DRIVE;
         side_ff      <= sqdrv_pkg::SIDE_0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work) begin
            mode_ff <= mode_in;
            side_ff <= side_in;
         end
      end
   end

   // payload: input register, turn latch, result register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_x_ff <= $signed(req_tdata[15:0]);
         in_y_ff <= $signed(req_tdata[31:16]);
         in_h_ff <= $signed(req_tdata[46:32]);
      end
      if (work && started) begin
         turn_heading_ff <= sqdrv_pkg::POS_W'(in_h_ff);
      end
      if (work) begin
         lin_ff      <= lin_in;
         ang_ff      <= ang_in;
         started_ff  <= started;
         mode_out_ff <= mode_in;
         side_out_ff <= side_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, side_out_ff, mode_out_ff, started_ff, ang_ff, lin_ff};

   // a started turn always reports turn mode with zero forward speed
   `SQDRV_ASSERT_IMP(a_start_in_turn, clock, reset, rsp_valid_ff && started_ff, mode_out_ff == sqdrv_pkg::MODE_TURN && lin_ff == '0)
   // entering turn mode advances the side by one
   `SQDRV_ASSERT_IMP(a_turn_advances_side, clock, reset, $rose(mode_ff), side_ff == 2'($past(side_ff) + 2'd1))
   // the side changes only on a turn start
   `SQDRV_ASSERT_IMP(a_side_only_on_start, clock, reset, side_ff != $past(side_ff) && !$past(reset), $rose(mode_ff))
   // a blocked input register keeps its item
   `SQDRV_ASSERT_NXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule

`default_nettype wire
